>>> rtl/segment_box_overlap_test_macros.svh
// ----------------------------------------------------------------------------
// segment_box_overlap_test_macros.svh
// Assertion shorthands for the segment/box overlap pipeline.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_OVERLAP_TEST_MACROS_SVH
`define SEGMENT_BOX_OVERLAP_TEST_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define SBOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("segment_box_overlap_test: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SBOT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("segment_box_overlap_test: assertion failed");

`else

`define SBOT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBOT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/sbot_pkg.sv
// ----------------------------------------------------------------------------
// sbot_pkg
// Shared constants for the segment/box overlap pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbot_pkg;

    // Number of spatial axes
    localparam int NUM_AXES = 3;

    // Growth of D = end - start and S = end + start - 2*center over a coordinate
    localparam int D_GROW = 1;
    localparam int S_GROW = 3;

endpackage

`default_nettype wire

>>> rtl/sbot_cross.sv
// ----------------------------------------------------------------------------
// sbot_cross
// One cross-product axis of the separating-axis test: registers the four
// products, then the difference and the bound, and compares
// |Da*Sb - Db*Sa| against 2*(Ha*|Db| + Hb*|Da|).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbot_cross #(
    parameter int COORD_BITS = 24
) (
    input  wire                                              i_clk,
    input  wire signed [COORD_BITS+sbot_pkg::D_GROW-1:0]     i_da,
    input  wire signed [COORD_BITS+sbot_pkg::D_GROW-1:0]     i_db,
    input  wire signed [COORD_BITS+sbot_pkg::S_GROW-1:0]     i_sa,
    input  wire signed [COORD_BITS+sbot_pkg::S_GROW-1:0]     i_sb,
    input  wire        [COORD_BITS+sbot_pkg::D_GROW-1:0]     i_mag_da,
    input  wire        [COORD_BITS+sbot_pkg::D_GROW-1:0]     i_mag_db,
    input  wire        [COORD_BITS-2:0]                      i_ha,
    input  wire        [COORD_BITS-2:0]                      i_hb,
    output logic                                             o_separates
);

    import sbot_pkg::*;

    localparam int DW = COORD_BITS + D_GROW;
    localparam int SW = COORD_BITS + S_GROW;
    localparam int HW = COORD_BITS - 1;
    localparam int PW = DW + SW;        // signed D*S product
    localparam int XW = PW + 1;         // difference of two products
    localparam int QW = HW + DW;        // unsigned H*|D| product
    localparam int BW = QW + 1;         // sum of two such products

    logic signed [PW-1:0] r_p_ab, r_p_ba;
    logic        [QW-1:0] r_q_a, r_q_b;
    logic signed [XW-1:0] r_cross;
    logic        [BW-1:0] r_bound;
    logic        [XW-1:0] w_cross_mag;
    logic        [XW-1:0] w_bound_x2;

    // Stage A: one multiplier per term
    always_ff @(posedge i_clk) begin
        r_p_ab <= i_da * i_sb;
        r_p_ba <= i_db * i_sa;
        r_q_a  <= i_ha * i_mag_db;
        r_q_b  <= i_hb * i_mag_da;
    end

    // Stage B: difference of the cross terms, sum of the bound terms
    always_ff @(posedge i_clk) begin
        r_cross <= XW'(r_p_ab) - XW'(r_p_ba);
        r_bound <= BW'(r_q_a) + BW'(r_q_b);
    end

    // Compare magnitude with twice the bound; a tie is not a separation
    assign w_cross_mag = r_cross[XW-1] ? XW'(-r_cross) : XW'(r_cross);
    assign w_bound_x2  = XW'({r_bound, 1'b0});
    assign o_separates = (w_cross_mag > w_bound_x2);

endmodule

`default_nettype wire

>>> rtl/segment_box_overlap_test.sv
// ----------------------------------------------------------------------------
// segment_box_overlap_test
// Six-axis separating-axis test between a line segment and an axis-aligned
// box, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive one word (segment start/end, box center, half extents) and raise
//   start. The word is taken at every rising edge with start high and busy
//   low; busy stays low, so a new word may enter in every cycle.
//   Each word yields one result: o_valid pulses for one cycle with
//   o_overlaps = 1 when no separating axis exists (ties count as overlap)
//   and 0 when the segment and box are separated.
//   Throughput is one word per cycle, set by the five register stages
//   (differences, magnitudes and box axes, products, combine, compare)
//   with one multiplier per product term.
//   Results come out in input order. The receiver cannot stall, and the
//   pipeline never holds: each result is shown for exactly one cycle.
//   Synchronous active-low reset clears all valid bits; words in flight are
//   dropped and no strobe follows for them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "segment_box_overlap_test_macros.svh"

module segment_box_overlap_test #(
    parameter int COORD_BITS = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [COORD_BITS-1:0]  i_seg_start_x,
    input  wire signed [COORD_BITS-1:0]  i_seg_start_y,
    input  wire signed [COORD_BITS-1:0]  i_seg_start_z,
    input  wire signed [COORD_BITS-1:0]  i_seg_end_x,
    input  wire signed [COORD_BITS-1:0]  i_seg_end_y,
    input  wire signed [COORD_BITS-1:0]  i_seg_end_z,
    input  wire signed [COORD_BITS-1:0]  i_box_center_x,
    input  wire signed [COORD_BITS-1:0]  i_box_center_y,
    input  wire signed [COORD_BITS-1:0]  i_box_center_z,
    input  wire        [COORD_BITS-2:0]  i_half_extent_x,
    input  wire        [COORD_BITS-2:0]  i_half_extent_y,
    input  wire        [COORD_BITS-2:0]  i_half_extent_z,
    output logic                         o_valid,
    output logic                         o_overlaps
);

    import sbot_pkg::*;

    localparam int DW = COORD_BITS + D_GROW;
    localparam int SW = COORD_BITS + S_GROW;
    localparam int HW = COORD_BITS - 1;

    // Per-axis views of the input word
    logic signed [COORD_BITS-1:0] w_st [NUM_AXES];
    logic signed [COORD_BITS-1:0] w_en [NUM_AXES];
    logic signed [COORD_BITS-1:0] w_ce [NUM_AXES];
    logic        [HW-1:0]         w_h  [NUM_AXES];

    // Stage 1: D, S, H
    logic signed [DW-1:0] r_d1 [NUM_AXES];
    logic signed [SW-1:0] r_s1 [NUM_AXES];
    logic        [HW-1:0] r_h1 [NUM_AXES];
    logic                 r_v1;

    // Stage 2: magnitudes and box-axis verdict
    logic signed [DW-1:0] r_d2    [NUM_AXES];
    logic signed [SW-1:0] r_s2    [NUM_AXES];
    logic        [HW-1:0] r_h2    [NUM_AXES];
    logic        [DW-1:0] r_dmag2 [NUM_AXES];
    logic                 r_box_sep2;
    logic                 r_v2;

    logic        [DW-1:0] w_dmag1 [NUM_AXES];
    logic        [SW-1:0] w_smag1 [NUM_AXES];
    logic        [SW-1:0] w_lim1  [NUM_AXES];
    logic [NUM_AXES-1:0]  w_box_miss1;

    // Stages 3 and 4: box verdict rides along the cross units
    logic                 r_box_sep3, r_box_sep4;
    logic                 r_v3, r_v4;

    // Stage 5: result register
    logic                 r_v5;
    logic                 r_overlaps5;

    logic [NUM_AXES-1:0]  w_cross_sep;
    logic                 w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_st[0] = i_seg_start_x;
    assign w_st[1] = i_seg_start_y;
    assign w_st[2] = i_seg_start_z;
    assign w_en[0] = i_seg_end_x;
    assign w_en[1] = i_seg_end_y;
    assign w_en[2] = i_seg_end_z;
    assign w_ce[0] = i_box_center_x;
    assign w_ce[1] = i_box_center_y;
    assign w_ce[2] = i_box_center_z;
    assign w_h[0]  = i_half_extent_x;
    assign w_h[1]  = i_half_extent_y;
    assign w_h[2]  = i_half_extent_z;

    // Advance valid bits every cycle; the pipeline never holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
        // Stage 1: doubled midpoint offset and direction, halvings removed
        always_ff @(posedge i_clk) begin
            r_d1[i] <= DW'(w_en[i]) - DW'(w_st[i]);
            r_s1[i] <= SW'(w_en[i]) + SW'(w_st[i]) - (SW'(w_ce[i]) <<< 1);
            r_h1[i] <= w_h[i];
        end

        // Box axis: miss when |S| > 2H + |D|
        assign w_dmag1[i] = r_d1[i][DW-1] ? DW'(-r_d1[i]) : DW'(r_d1[i]);
        assign w_smag1[i] = r_s1[i][SW-1] ? SW'(-r_s1[i]) : SW'(r_s1[i]);
        assign w_lim1[i]  = (SW'(r_h1[i]) << 1) + SW'(w_dmag1[i]);
        assign w_box_miss1[i] = (w_smag1[i] > w_lim1[i]);

        // Stage 2: hold operands for the cross units
        always_ff @(posedge i_clk) begin
            r_d2[i]    <= r_d1[i];
            r_s2[i]    <= r_s1[i];
            r_h2[i]    <= r_h1[i];
            r_dmag2[i] <= w_dmag1[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_box_sep2 <= |w_box_miss1;
        r_box_sep3 <= r_box_sep2;
        r_box_sep4 <= r_box_sep3;
    end

    // Stages 3 and 4: one cross unit per edge-direction axis
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_cross
        localparam int A = (k + 1) % NUM_AXES;
        localparam int B = (k + 2) % NUM_AXES;

        sbot_cross #(
            .COORD_BITS (COORD_BITS)
        ) u_cross (
            .i_clk       (i_clk),
            .i_da        (r_d2[A]),
            .i_db        (r_d2[B]),
            .i_sa        (r_s2[A]),
            .i_sb        (r_s2[B]),
            .i_mag_da    (r_dmag2[A]),
            .i_mag_db    (r_dmag2[B]),
            .i_ha        (r_h2[A]),
            .i_hb        (r_h2[B]),
            .o_separates (w_cross_sep[k])
        );
    end

    // Stage 5: overlap when no axis separates
    always_ff @(posedge i_clk) begin
        r_overlaps5 <= !(r_box_sep4 || (|w_cross_sep));
    end

    assign o_valid    = r_v5;
    assign o_overlaps = r_overlaps5;

    // An accepted word enters the pipeline
    `SBOT_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, w_accept, r_v1)
    // No strobe unless stage 4 held a word
    `SBOT_ASSERT_NXT(a_no_phantom, i_clk, i_rst_n, !r_v4, !o_valid)
    // A box-axis miss always ends as a reported miss
    `SBOT_ASSERT_IMP(a_box_miss, i_clk, i_rst_n, r_v2 && r_box_sep2, ##3 (o_valid && !o_overlaps))
    // A point segment inside the box slabs always overlaps
    `SBOT_ASSERT_IMP(a_point_hit, i_clk, i_rst_n, r_v2 && !r_box_sep2 && r_d2[0] == '0 && r_d2[1] == '0 && r_d2[2] == '0, ##3 (o_valid && o_overlaps))

endmodule

`default_nettype wire

>>> tb/sv/tb_segment_box_overlap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_box_overlap_test
// Self-checking bench for the segment/box separating-axis overlap pipeline.
// A queue of words (directed corner, face and extreme cases first, then
// random words in several shapes) feeds a clocked driver that pauses at
// random. Every accepted word is run through a local integer model of the
// six-axis test, and a clocked monitor compares each result strobe with the
// oldest expected flag.
// ----------------------------------------------------------------------------

module tb_segment_box_overlap_test;

    localparam int CB = 24;
    localparam int NUM_RANDOM = 550;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 50000;
    localparam int C_MAX = 8388607;
    localparam int C_MIN = -8388608;
    localparam int H_MAX = 8388607;

    typedef struct packed {
        logic [2:0][CB-1:0] seg_start;
        logic [2:0][CB-1:0] seg_end;
        logic [2:0][CB-1:0] box_center;
        logic [2:0][CB-2:0] half_extent;
    } seg_box_word_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic          o_valid;
    logic          o_overlaps;
    seg_box_word_t drv_word = '0;

    seg_box_word_t pending_words[$];
    bit            overlap_expected[$];
    int            total_words = 1;
    int            accepted_words = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            want_overlap;

    segment_box_overlap_test #(.COORD_BITS(CB)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_seg_start_x  (drv_word.seg_start[0]),
        .i_seg_start_y  (drv_word.seg_start[1]),
        .i_seg_start_z  (drv_word.seg_start[2]),
        .i_seg_end_x    (drv_word.seg_end[0]),
        .i_seg_end_y    (drv_word.seg_end[1]),
        .i_seg_end_z    (drv_word.seg_end[2]),
        .i_box_center_x (drv_word.box_center[0]),
        .i_box_center_y (drv_word.box_center[1]),
        .i_box_center_z (drv_word.box_center[2]),
        .i_half_extent_x(drv_word.half_extent[0]),
        .i_half_extent_y(drv_word.half_extent[1]),
        .i_half_extent_z(drv_word.half_extent[2]),
        .o_valid        (o_valid),
        .o_overlaps     (o_overlaps)
    );

    // 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Exact separating-axis test on 64-bit integers: box axes, then the
    // edge cross axes, one per pair of axes; a tie never separates.
    function automatic bit predict_overlap(input seg_box_word_t w);
        longint d[3];
        longint s[3];
        longint hh[3];
        longint ad[3];
        longint as;
        longint cr;
        longint lim;
        int     a;
        int     b;
        bit     hit;
        hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(w.seg_end[i])) - longint'($signed(w.seg_start[i]));
            s[i] = longint'($signed(w.seg_end[i])) + longint'($signed(w.seg_start[i]))
                 - 2 * longint'($signed(w.box_center[i]));
            hh[i] = longint'({1'b0, w.half_extent[i]});
            ad[i] = (d[i] < 0) ? -d[i] : d[i];
            as = (s[i] < 0) ? -s[i] : s[i];
            if (as > 2 * hh[i] + ad[i])
                hit = 1'b0;
        end
        if (hit) begin
            for (int k = 0; k < 3; k++) begin
                a = (k + 1) % 3;
                b = (k + 2) % 3;
                cr = d[a] * s[b] - d[b] * s[a];
                if (cr < 0)
                    cr = -cr;
                lim = 2 * (hh[a] * ad[b] + hh[b] * ad[a]);
                if (cr > lim)
                    hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // Signed value in [-lim, lim]
    function automatic int srand(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic void put_axis(inout seg_box_word_t w, input int ax, input int st,
                                     input int en, input int ce, input int h);
        w.seg_start[ax] = CB'(st);
        w.seg_end[ax] = CB'(en);
        w.box_center[ax] = CB'(ce);
        w.half_extent[ax] = (CB-1)'(h);
    endfunction

    function automatic seg_box_word_t make_word(input int sx, input int sy, input int sz,
                                                input int ex, input int ey, input int ez,
                                                input int cx, input int cy, input int cz,
                                                input int hx, input int hy, input int hz);
        seg_box_word_t w;
        w = '0;
        put_axis(w, 0, sx, ex, cx, hx);
        put_axis(w, 1, sy, ey, cy, hy);
        put_axis(w, 2, sz, ez, cz, hz);
        return w;
    endfunction

    // Segment in the plane of two axes whose line grazes a box edge: exact
    // tie on the cross axis for nudge 0, just outside or inside otherwise.
    function automatic seg_box_word_t corner_word(input int rot, input int m, input int nudge,
                                                  input int hc, input int off, input int ca,
                                                  input int cb, input int cc);
        seg_box_word_t w;
        w = '0;
        put_axis(w, rot, ca - 2 * m, ca + 4 * m, ca, m);
        put_axis(w, (rot + 1) % 3, cb + 4 * m + nudge, cb - 2 * m, cb, m);
        put_axis(w, (rot + 2) % 3, cc + off, cc + off, cc, hc);
        return w;
    endfunction

    // Endpoint on, just inside or just outside one face, segment pointing out
    function automatic seg_box_word_t face_word();
        seg_box_word_t w;
        int f;
        int sgn;
        int h;
        int ce;
        int p;
        int ext;
        w = '0;
        f = $urandom_range(0, 2);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        ext = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 1000));
        for (int i = 0; i < 3; i++) begin
            h = $urandom_range(0, 1 << 20);
            ce = srand(1 << 21);
            if (i == f) begin
                p = ce + sgn * (h + srand(1));
                put_axis(w, i, p, p + sgn * ext, ce, h);
            end else begin
                p = ce + srand(h);
                put_axis(w, i, p, p, ce, h);
            end
        end
        return w;
    endfunction

    // Segment and box at one random scale, so hits and misses both occur
    function automatic seg_box_word_t cluster_word();
        seg_box_word_t w;
        int sc;
        int ce;
        int st;
        bit point;
        w = '0;
        sc = 1 << $urandom_range(0, 20);
        point = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < 3; i++) begin
            ce = srand(2 * sc);
            st = ce + srand(3 * sc);
            put_axis(w, i, st, point ? st : ce + srand(3 * sc), ce,
                     int'($urandom_range(0, sc)));
        end
        return w;
    endfunction

    function automatic seg_box_word_t any_word();
        seg_box_word_t w;
        for (int i = 0; i < 3; i++) begin
            w.seg_start[i] = CB'($urandom);
            w.seg_end[i] = CB'($urandom);
            w.box_center[i] = CB'($urandom);
            w.half_extent[i] = (CB-1)'($urandom);
        end
        return w;
    endfunction

    // Sender pause rate per third of the run: light, heavy, none
    function automatic int idle_percent();
        case (accepted_words * 3 / total_words)
            0: return 6;
            1: return 60;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Stimulus, reset and end of run
    initial begin
        seg_box_word_t w;

        // Extremes of every field
        pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                          C_MAX, C_MAX, C_MAX, H_MAX, H_MAX, H_MAX));
        pending_words.push_back(make_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                                          0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                                          C_MIN, C_MIN, C_MIN, H_MAX, H_MAX, H_MAX));
        pending_words.push_back(make_word(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                          C_MAX, C_MAX, C_MAX, 0, 0, 0));
        pending_words.push_back(make_word(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX,
                                          C_MAX, C_MIN, C_MAX, H_MAX, 0, H_MAX));
        // Degenerate segment on a face, then one step outside, then on another face
        pending_words.push_back(make_word(5, 0, 0, 5, 0, 0, 0, 0, 0, 5, 5, 5));
        pending_words.push_back(make_word(6, 0, 0, 6, 0, 0, 0, 0, 0, 5, 5, 5));
        pending_words.push_back(make_word(0, -8, 0, 0, -8, 0, 0, -3, 0, 5, 5, 5));
        // Point box: segment through it, then one that passes beside it
        pending_words.push_back(make_word(-4, -4, -4, 4, 4, 4, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(-4, -3, -4, 4, 5, 4, 0, 0, 0, 0, 0, 0));
        // Flat box crossed, then flat box moved clear
        pending_words.push_back(make_word(-5, 1, 1, 5, 2, 2, 0, 0, 0, 0, 10, 10));
        pending_words.push_back(make_word(-5, 1, 1, 5, 2, 2, 6, 0, 0, 0, 10, 10));
        // Edge cross axes: tie and just outside on all three pairs, then just inside and a large tie
        for (int r = 0; r < 3; r++) begin
            pending_words.push_back(corner_word(r, 1, 0, 1, 0, 0, 0, 0));
            pending_words.push_back(corner_word(r, 1, 1, 1, 0, 0, 0, 0));
        end
        pending_words.push_back(corner_word(0, 1000, -1, 7, 3, 0, 0, 0));
        pending_words.push_back(corner_word(1, 1 << 20, 0, 1 << 20, -5, 100, -100, 9));

        // Random words, mostly shaped near the decision boundaries
        for (int n = 0; n < NUM_RANDOM; n++) begin
            case ($urandom_range(0, 9))
                0, 1:    w = any_word();
                2, 3, 4: w = cluster_word();
                5, 6:    w = face_word();
                default: w = corner_word($urandom_range(0, 2), $urandom_range(1, 1 << 20),
                                         srand(1), $urandom_range(0, 1 << 20),
                                         srand(1 << 10), srand(1 << 21), srand(1 << 21),
                                         srand(1 << 21));
            endcase
            // flip direction now and then
            if ($urandom_range(0, 1)) begin
                w.seg_start ^= w.seg_end;
                w.seg_end ^= w.seg_start;
                w.seg_start ^= w.seg_end;
            end
            pending_words.push_back(w);
        end
        total_words = pending_words.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every word to be taken and every result to return
        while (pending_words.size() != 0 || overlap_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Driver: retire the taken word, hold a refused one, else pick or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                overlap_expected.push_back(predict_overlap(drv_word));
                void'(pending_words.pop_front());
                accepted_words++;
            end
            if (!(start && busy)) begin
                if (pending_words.size() != 0 && int'($urandom_range(0, 99)) >= idle_percent()) begin
                    drv_word <= pending_words[0];
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expected flag
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (overlap_expected.size() == 0) begin
                report_mismatch("result strobe with no word outstanding");
            end else begin
                want_overlap = overlap_expected.pop_front();
                if (o_overlaps !== want_overlap)
                    report_mismatch($sformatf("overlaps got %b want %b", o_overlaps,
                                              want_overlap));
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     overlap_expected.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
